### rtl/ftprd_pkg.sv
// Shared types and constants for the FTP reply end detector.
// No dependencies; compile this file first.
`default_nettype none

package ftprd_pkg;

  // Payload types.
  typedef logic [7:0] byte_t;
  typedef logic [1:0] status_t;
  typedef logic [9:0] code_t;
  typedef logic [3:0] digit_t;

  // Status codes carried with each result.
  localparam status_t STATUS_BUSY = 2'd0;
  localparam status_t STATUS_DONE = 2'd1;
  localparam status_t STATUS_BAD  = 2'd2;

  // Characters of interest in the reply text.
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_HYPHEN  = 8'h2D;
  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_ZERO    = 8'h30;
  localparam byte_t CH_NINE    = 8'h39;

  // A reply code has three digits; the digit counter saturates one above that.
  localparam logic [2:0] CODE_LEN  = 3'd3;
  localparam logic [2:0] DIGIT_SAT = 3'd4;

  // True for an ASCII decimal digit.
  function automatic logic is_digit(input byte_t b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

### rtl/ftprd_byte_if.sv
// Valid/ready channel that carries one received reply byte per transfer.
// Depends on ftprd_pkg.
`default_nettype none

interface ftprd_byte_if;
  import ftprd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/ftprd_result_if.sv
// Valid/ready channel that carries one detector result per transfer.
// Depends on ftprd_pkg.
`default_nettype none

interface ftprd_result_if;
  import ftprd_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  code_t   reply_code;
  logic    was_multi_line;

  modport source (output valid, output status, output reply_code, output was_multi_line,
                  input ready);
  modport sink (input valid, input status, input reply_code, input was_multi_line,
                output ready);
endinterface

`default_nettype wire

### rtl/ftp_reply_end_detector.sv
// Top level of the FTP control reply end detector: parser state and result register.
// Depends on ftprd_pkg, ftprd_byte_if and ftprd_result_if.
//
//   Channel   Role    Transfer payload
//   rx        sink    rx_byte: one byte of reply text
//   result    source  status, reply_code, was_multi_line: one result per byte
//
// Every byte transfer yields exactly one result, held in the result register from the cycle after the transfer.
// A byte may be taken in every cycle; the single result register sets that rate, and
// rx.ready is low only while that register holds a result that has not been taken.
// Synchronous reset clears the parser to the code phase and empties the result register.
// Result payload holds steady while result.ready is low.
`default_nettype none

module ftp_reply_end_detector (
  input  wire                   clk,
  input  wire                   rst,
  ftprd_byte_if.sink            rx,
  ftprd_result_if.source        result
);
  import ftprd_pkg::*;

  // Parser phases.
  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd1;
  localparam logic [1:0] PH_MULTI = 2'd2;

  // Parser state.
  logic [1:0] phase, phase_next;
  logic [2:0] digit_count, digit_count_next;
  digit_t     code_digits [3];
  digit_t     code_digits_next [3];
  logic [1:0] match_count, match_count_next;
  logic       at_line_head, at_line_head_next;
  logic       multi_flag, multi_flag_next;

  // Result register.
  logic    res_valid;
  status_t res_status;
  code_t   res_code;
  logic    res_multi;

  // Result of the byte now on the input.
  status_t status_next;
  code_t   code_next;
  logic    multi_next;

  logic   accept;
  byte_t  b;
  digit_t expect_digit;
  code_t  code_value;

  // A new byte is taken whenever the result register is free or being emptied.
  assign rx.ready = !res_valid || result.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // Digit that the current position of a body line must match.
  always_comb begin
    unique case (match_count)
      2'd0:    expect_digit = code_digits[0];
      2'd1:    expect_digit = code_digits[1];
      default: expect_digit = code_digits[2];
    endcase
  end

  // Reply code as a number from its three stored digits.
  assign code_value = code_t'({6'd0, code_digits[0]} * 10'd100)
                    + code_t'({6'd0, code_digits[1]} * 10'd10)
                    + {6'd0, code_digits[2]};

  // Next parser state and the result for this byte.
  always_comb begin
    phase_next        = phase;
    digit_count_next  = digit_count;
    code_digits_next  = code_digits;
    match_count_next  = match_count;
    at_line_head_next = at_line_head;
    multi_flag_next   = multi_flag;
    status_next       = STATUS_BUSY;
    code_next         = '0;
    multi_next        = 1'b0;

    unique case (phase)
      PH_LAST: begin
        // The reply ends at the first newline of its last line.
        if (b == CH_NEWLINE) begin
          status_next       = STATUS_DONE;
          code_next         = code_value;
          multi_next        = multi_flag;
          phase_next        = PH_CODE;
          digit_count_next  = '0;
          code_digits_next  = '{default: '0};
          match_count_next  = '0;
          at_line_head_next = 1'b1;
          multi_flag_next   = 1'b0;
        end
      end
      PH_MULTI: begin
        // Look for a line that opens with the code digits and then a space.
        if (b == CH_NEWLINE) begin
          at_line_head_next = 1'b1;
          match_count_next  = '0;
        end else if (at_line_head) begin
          if (match_count == 2'd3) begin
            if (b == CH_SPACE) begin
              phase_next = PH_LAST;
            end
            at_line_head_next = 1'b0;
            match_count_next  = '0;
          end else if (is_digit(b) && (b[3:0] == expect_digit)) begin
            match_count_next = match_count + 2'd1;
          end else begin
            at_line_head_next = 1'b0;
            match_count_next  = '0;
          end
        end
      end
      default: begin
        // Code phase: collect digits until a space or a hyphen.
        if ((b == CH_SPACE) || (b == CH_HYPHEN)) begin
          if (digit_count != CODE_LEN) begin
            status_next       = STATUS_BAD;
            phase_next        = PH_CODE;
            digit_count_next  = '0;
            code_digits_next  = '{default: '0};
            match_count_next  = '0;
            at_line_head_next = 1'b1;
            multi_flag_next   = 1'b0;
          end else if (b == CH_SPACE) begin
            phase_next      = PH_LAST;
            multi_flag_next = 1'b0;
          end else begin
            phase_next        = PH_MULTI;
            multi_flag_next   = 1'b1;
            at_line_head_next = 1'b0;
            match_count_next  = '0;
          end
        end else if (is_digit(b)) begin
          if (digit_count < CODE_LEN) begin
            code_digits_next[digit_count[1:0]] = b[3:0];
          end
          if (digit_count < DIGIT_SAT) begin
            digit_count_next = digit_count + 3'd1;
          end
        end
      end
    endcase
  end

  // Parser state advances on each byte transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CODE;
      digit_count  <= '0;
      code_digits  <= '{default: '0};
      match_count  <= '0;
      at_line_head <= 1'b1;
      multi_flag   <= 1'b0;
    end else if (accept) begin
      phase        <= phase_next;
      digit_count  <= digit_count_next;
      code_digits  <= code_digits_next;
      match_count  <= match_count_next;
      at_line_head <= at_line_head_next;
      multi_flag   <= multi_flag_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each byte transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_code   <= code_next;
      res_multi  <= multi_next;
    end
  end

  assign result.valid          = res_valid;
  assign result.status         = res_status;
  assign result.reply_code     = res_code;
  assign result.was_multi_line = res_multi;

  // The digit counter never passes its saturation value.
  a_digit_sat: assert property (@(posedge clk) disable iff (rst)
    digit_count <= DIGIT_SAT)
    else $error("digit counter beyond saturation");

  // The multi-line flag is only set once the code phase has been left.
  a_multi_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CODE) |-> !multi_flag)
    else $error("multi-line flag set in code phase");

  // A finished or malformed reply re-arms the parser.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && (status_next != STATUS_BUSY)) |=>
      ((phase == PH_CODE) && (digit_count == 3'd0) && at_line_head))
    else $error("parser not re-armed after a result");

  // A presented result never carries the unused status code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res_status == STATUS_BUSY) || (res_status == STATUS_DONE)
                   || (res_status == STATUS_BAD)))
    else $error("unused status code presented");

  // A completed reply carries a three-digit code.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_status == STATUS_DONE)) |-> (res_code <= 10'd999))
    else $error("reply code out of range");

endmodule

`default_nettype wire

### bench/tb_ftp_reply_end_detector.sv
`timescale 1ns / 1ps
// Self-checking bench for the FTP reply end detector: directed bytes, then random replies.
// Depends on ftprd_pkg, ftprd_byte_if, ftprd_result_if and ftp_reply_end_detector.
module tb_ftp_reply_end_detector;
  import ftprd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    PH_CODE  = 2'd0,
    PH_LAST  = 2'd1,
    PH_MULTI = 2'd2,
    PH_SPARE = 2'd3
  } parse_phase_e;

  typedef struct packed {
    status_t status;
    code_t   code;
    logic    multi;
  } reply_result_t;

  typedef struct packed {
    byte_t         b;
    logic          use_typed;
    reply_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  ftprd_byte_if   rx ();
  ftprd_result_if result ();

  ftp_reply_end_detector dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .result (result)
  );

  // Parser state as the bench sees it.
  parse_phase_e ph;
  logic [2:0]   n_digits;
  digit_t       code_dig [3];
  logic [1:0]   n_matched;
  logic         line_head;
  logic         multi_seen;

  reply_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  digit_t        gen_code [3];
  int unsigned   bytes_sent = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_cnt = 0;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter; the run is abandoned if it goes on far too long.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A window in which neither side idles.
  function automatic logic quiet_span();
    return (cycle_cnt >= 600) && (cycle_cnt < 1000);
  endfunction

  // Returns the parser to the start of a reply.
  function automatic void clear_parser();
    ph = PH_CODE;
    n_digits = 3'd0;
    code_dig[0] = 4'd0;
    code_dig[1] = 4'd0;
    code_dig[2] = 4'd0;
    n_matched = 2'd0;
    line_head = 1'b1;
    multi_seen = 1'b0;
  endfunction

  // Advances the parser by one byte and returns the result that byte produces.
  function automatic reply_result_t track_reply_byte(input byte_t b);
    reply_result_t r;
    r = '0;
    case (ph)
      PH_LAST: begin
        if (b == CH_NEWLINE) begin
          r.status = STATUS_DONE;
          r.code = {6'd0, code_dig[0]} * 10'd100 + {6'd0, code_dig[1]} * 10'd10
                 + {6'd0, code_dig[2]};
          r.multi = multi_seen;
          clear_parser();
        end
      end
      PH_MULTI: begin
        if (b == CH_NEWLINE) begin
          line_head = 1'b1;
          n_matched = 2'd0;
        end else if (line_head) begin
          if (n_matched >= CODE_LEN) begin
            // Only a space right after the full code marks the last line.
            if (b == CH_SPACE)
              ph = PH_LAST;
            line_head = 1'b0;
            n_matched = 2'd0;
          end else if (b >= CH_ZERO && b <= CH_NINE && b[3:0] == code_dig[n_matched]) begin
            n_matched = n_matched + 2'd1;
          end else begin
            line_head = 1'b0;
            n_matched = 2'd0;
          end
        end
      end
      default: begin
        // Code phase; the unused phase value behaves the same way.
        if (b == CH_SPACE || b == CH_HYPHEN) begin
          if (n_digits != CODE_LEN) begin
            r.status = STATUS_BAD;
            clear_parser();
          end else if (b == CH_SPACE) begin
            ph = PH_LAST;
            multi_seen = 1'b0;
          end else begin
            ph = PH_MULTI;
            multi_seen = 1'b1;
            line_head = 1'b0;
            n_matched = 2'd0;
          end
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          if (n_digits < CODE_LEN)
            code_dig[n_digits] = b[3:0];
          if (n_digits < DIGIT_SAT)
            n_digits = n_digits + 3'd1;
        end
      end
    endcase
    return r;
  endfunction

  // Offers one byte, waits for its transfer and records the result it should give.
  task automatic send_byte(input byte_t b, input logic use_typed, input reply_result_t typed_want);
    reply_result_t predicted;
    while (!quiet_span() && $urandom_range(99) < 10) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready)
      @(posedge clk);
    predicted = track_reply_byte(b);
    pending_results.push_back(use_typed ? typed_want : predicted);
    bytes_sent++;
  endtask

  // Sends the first n digits of the current reply code.
  task automatic send_code_prefix(input int unsigned n);
    for (int i = 0; i < n; i++)
      send_byte(CH_ZERO + byte_t'(gen_code[i]), 1'b0, '0);
  endtask

  // Sends free text with no newline in it, mostly printable.
  task automatic send_text(input int unsigned max_len);
    int unsigned len;
    byte_t       b;
    len = $urandom_range(max_len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(3) == 0)
        b = $urandom_range(255);
      else
        b = $urandom_range(126, 32);
      if (b == CH_NEWLINE)
        b = CH_SPACE;
      send_byte(b, 1'b0, '0);
    end
  endtask

  task automatic add_row(input byte_t b, input logic use_typed, input status_t st,
                         input code_t code, input logic multi);
    stim_row_t row;
    row.b = b;
    row.use_typed = use_typed;
    row.want = '{st, code, multi};
    directed_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input reply_result_t want,
                               input reply_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s): expected status %0d code %0d multi %0d, got %0d %0d %0d",
               what, want.status, want.code, want.multi, got.status, got.code, got.multi);
  endtask

  // Receiver stalls at random, except inside the quiet window.
  always @(posedge clk) begin
    if (rst)
      result.ready <= 1'b0;
    else
      result.ready <= quiet_span() || ($urandom_range(99) >= 10);
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    reply_result_t want;
    reply_result_t got;
    if (!rst && result.valid && result.ready) begin
      got = {result.status, result.reply_code, result.was_multi_line};
      if (pending_results.size() == 0) begin
        note_mismatch("no result expected", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.code !== want.code || got.multi !== want.multi)
          note_mismatch("result fields", want, got);
      end
    end
  end

  // Stimulus: directed table first, then random replies.
  initial begin
    int unsigned pick;
    int unsigned n;
    rst = 1'b1;
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    result.ready = 1'b0;
    clear_parser();

    // Stray bytes straight after reset: a bare space, the low extreme, a newline.
    add_row(CH_SPACE, 1'b1, STATUS_BAD, 10'd0, 1'b0);
    add_row(8'h00, 1'b1, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_NEWLINE, 1'b1, STATUS_BUSY, 10'd0, 1'b0);
    // Single-line reply with code zero and the high extreme in its text.
    repeat (3) add_row("0", 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_SPACE, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(8'hFF, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_NEWLINE, 1'b1, STATUS_DONE, 10'd0, 1'b0);
    // Four digits saturate the count, so the hyphen is malformed.
    repeat (4) add_row("9", 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_HYPHEN, 1'b1, STATUS_BAD, 10'd0, 1'b0);
    // Multi-line reply: a body line with code then hyphen stays ordinary.
    repeat (3) add_row("9", 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_HYPHEN, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_NEWLINE, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    repeat (3) add_row("9", 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_HYPHEN, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_NEWLINE, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    repeat (3) add_row("9", 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_SPACE, 1'b0, STATUS_BUSY, 10'd0, 1'b0);
    add_row(CH_NEWLINE, 1'b1, STATUS_DONE, 10'd999, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].use_typed, directed_rows[i].want);

    while (bytes_sent < directed_rows.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      for (int i = 0; i < 3; i++)
        gen_code[i] = $urandom_range(9);
      if (pick < 40) begin
        // Well-formed single-line reply.
        send_code_prefix(3);
        send_byte(CH_SPACE, 1'b0, '0);
        send_text(12);
        send_byte(CH_NEWLINE, 1'b0, '0);
      end else if (pick < 80) begin
        // Well-formed multi-line reply with body lines that resemble the last line.
        send_code_prefix(3);
        send_byte(CH_HYPHEN, 1'b0, '0);
        send_text(12);
        send_byte(CH_NEWLINE, 1'b0, '0);
        repeat ($urandom_range(3)) begin
          case ($urandom_range(3))
            0: ;
            1: begin
              send_code_prefix($urandom_range(2));
              send_byte($urandom_range(255), 1'b0, '0);
            end
            2: begin
              send_code_prefix(3);
              send_byte(($urandom_range(1) == 0) ? CH_HYPHEN : byte_t'($urandom_range(255)),
                        1'b0, '0);
            end
            default: send_byte($urandom_range(57, 48), 1'b0, '0);
          endcase
          send_text(10);
          send_byte(CH_NEWLINE, 1'b0, '0);
        end
        send_code_prefix(3);
        send_byte(CH_SPACE, 1'b0, '0);
        send_text(12);
        send_byte(CH_NEWLINE, 1'b0, '0);
      end else if (pick < 90) begin
        // Code of the wrong length, closed by a space or a hyphen.
        n = $urandom_range(4);
        if (n >= 3)
          n++;
        repeat (n) send_byte($urandom_range(57, 48), 1'b0, '0);
        send_byte(($urandom_range(1) == 0) ? CH_SPACE : CH_HYPHEN, 1'b0, '0);
      end else begin
        // Arbitrary bytes.
        repeat ($urandom_range(6, 1)) send_byte($urandom_range(255), 1'b0, '0);
      end
    end
    rx.valid <= 1'b0;

    // Wait for every result, then go on watching for anything unexpected before the verdict.
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
